/* hdl/sps_pkg.sv */
// sps_pkg: shared constants and types of the streaming prime sieve
// no dependencies; used by sps_rem and streaming_prime_sieve_core

package sps_pkg;

   // default configuration of the sieve
   localparam int DEF_MAX_PRIMES  = 64;
   localparam int DEF_VALUE_WIDTH = 16;

   // fixed port widths of the item fields
   localparam int CANDIDATE_WIDTH = 16;
   localparam int INDEX_WIDTH     = 7;

   // status returned by the remainder unit
   typedef struct packed {
      logic done;  // one-cycle pulse, remainder ready
      logic zero;  // remainder is zero, valid with done
   } rem_status_type;

endpackage

/* hdl/sps_ram.sv */
// sps_ram: generic single-write, single-read RAM with registered read data
// no package dependency

module sps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sps_rem.sv */
// sps_rem: iterative restoring remainder unit, one dividend bit per cycle
// depends on sps_pkg for the status struct

module sps_rem #(
   parameter int VALUE_WIDTH = sps_pkg::DEF_VALUE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_WIDTH-1:0]  dividend,
   input  logic [VALUE_WIDTH-1:0]  divisor,
   output sps_pkg::rem_status_type status
);

   localparam int CNTW = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   // shift in next dividend bit, subtract divisor when it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
         dvd_in = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule

/* hdl/streaming_prime_sieve_core.sv */
// streaming_prime_sieve_core: incremental prime sieve over a candidate stream
// Each accepted candidate walks the stored primes in order: fetch, test, and a modulo
// for each entry not above the candidate; then emit, unless a divisor was found.
// One item at a time: a new candidate is accepted only after the last is finished.
// Reset: synchronous, clears the stored-prime count and the handshake state.
// Depends on sps_pkg, sps_ram, sps_rem.

module streaming_prime_sieve_core #(
   parameter int MAX_PRIMES  = sps_pkg::DEF_MAX_PRIMES,
   parameter int VALUE_WIDTH = sps_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sps_pkg::CANDIDATE_WIDTH-1:0] req_candidate,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sps_pkg::CANDIDATE_WIDTH-1:0] rsp_prime_value,
   output logic [sps_pkg::INDEX_WIDTH-1:0]     rsp_prime_index,
   output logic                                rsp_table_full
);

   localparam int AW  = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int CW  = $clog2(MAX_PRIMES + 1);
   localparam int VW  = VALUE_WIDTH;
   localparam int CDW = sps_pkg::CANDIDATE_WIDTH;
   localparam int IW  = sps_pkg::INDEX_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_TEST,
      S_DIV,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [VW-1:0]           value_ff, value_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CDW-1:0]          rsp_value_ff, rsp_value_in;
   logic [IW-1:0]           rsp_index_ff, rsp_index_in;
   logic                    rsp_full_ff, rsp_full_in;

   logic [VW+CDW-1:0]       cand_pad;
   logic [VW-1:0]           cand_v;
   logic [VW+CDW-1:0]       value_pad;
   logic [CW+IW-1:0]        index_pad;
   logic                    table_full;

   logic                    wr_en;
   logic                    rd_en;
   logic [VW-1:0]           rd_data;
   logic                    rem_start;
   sps_pkg::rem_status_type rem_st;

   // prime table
   sps_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_PRIMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // shared modulo unit
   sps_rem #(
      .VALUE_WIDTH (VW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (value_ff),
      .divisor  (rd_data),
      .status   (rem_st)
   );

   // width adaption of candidate and result fields
   assign cand_pad   = {{VW{1'b0}}, req_candidate};
   assign cand_v     = cand_pad[VW-1:0];
   assign value_pad  = {{CDW{1'b0}}, value_ff};
   assign table_full = (count_ff == CW'(MAX_PRIMES));
   assign index_pad  = {{IW{1'b0}}, count_ff};

   // sequencer: walk stored primes, one modulo at a time
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_full_in  = rsp_full_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rem_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = cand_v;
               idx_in   = '0;
               if (req_restart) begin
                  count_in = '0;
               end
               if (cand_v >= VW'(2)) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (idx_ff == count_ff) begin
               state_in = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            // entry above the candidate (or empty) cannot divide it
            if (rd_data == '0 || rd_data > value_ff) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end else begin
               rem_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_st.done) begin
               if (rem_st.zero) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_FETCH;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_pad[CDW-1:0];
               rsp_full_in  = table_full;
               rsp_index_in = index_pad[IW-1:0];
               if (!table_full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_prime_index = rsp_index_ff;
   assign rsp_table_full  = rsp_full_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PRIMES))
      else $error("stored-prime count beyond table depth");

   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emit step");

   a_rem_start: assert property (@(posedge clock) disable iff (reset)
      rem_start |-> (state_ff == S_TEST) && (rd_data != '0) && (rd_data <= value_ff))
      else $error("modulo started with an unusable divisor");

endmodule
